[hdl/bfr_pkg.sv]
// Shared types and constants of the bitmap font text renderer.
`timescale 1ns / 1ps

package bfr_pkg;

    localparam int FONT_CHARS     = 256;
    localparam int MAX_GLYPH_ROWS = 16;
    localparam int FONT_DEPTH     = FONT_CHARS * MAX_GLYPH_ROWS;
    localparam int FONT_ADDR_W    = $clog2(FONT_DEPTH);
    localparam int ROW_IDX_W      = $clog2(MAX_GLYPH_ROWS);
    localparam int CUR_W          = 12;
    localparam int ADDR_W         = 24;
    localparam int COLOR_W        = 32;
    localparam int GLYPH_W        = 8;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [3:0] MAX_WIDTH    = 4'd8;
    localparam logic [4:0] MAX_HEIGHT   = 5'(MAX_GLYPH_ROWS);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_GLYPH_WIDTH  = 2'd1,
        CFG_GLYPH_HEIGHT = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

    // Request kinds carried in tuser
    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_PUT  = 2'd1,
        REQ_HOME = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef struct packed {
        logic [12:0] frame_width;
        logic [3:0]  glyph_width;
        logic [4:0]  glyph_height;
    } t_cfg;

    typedef struct packed {
        t_req                 req_type;
        logic [7:0]           char_code;
        logic [3:0]           glyph_row;
        logic [GLYPH_W-1:0]   glyph_bits;
        logic [COLOR_W-1:0]   fg_color;
        logic [COLOR_W-1:0]   bg_color;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0]    row_address;
        logic [GLYPH_W-1:0]   row_bits;
        logic [COLOR_W-1:0]   fg_color_out;
        logic [COLOR_W-1:0]   bg_color_out;
        logic                 last_row;
    } t_row_out;

    // Font store port driven by the sequencer
    typedef struct packed {
        logic                   we;
        logic [FONT_ADDR_W-1:0] waddr;
        logic [GLYPH_W-1:0]     wdata;
        logic                   re;
        logic [FONT_ADDR_W-1:0] raddr;
    } t_font_port;

endpackage

[hdl/bfr_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered: data valid in the cycle after the enable, held otherwise
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/bfr_ctrl.sv]
// Request sequencer: font loads, cursor, glyph row reads and the result register.
`timescale 1ns / 1ps

module bfr_ctrl import bfr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  t_item              i_item,
    output t_font_port         o_font,
    input  logic [GLYPH_W-1:0] i_font_rdata,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output t_row_out           o_row
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [CUR_W-1:0]     r_cx, n_cx;
    logic [CUR_W-1:0]     r_cy, n_cy;
    logic [ROW_IDX_W-1:0] r_row, n_row;
    logic                 r_mvalid, n_mvalid;

    logic [7:0]           r_ch;
    logic [COLOR_W-1:0]   r_fg;
    logic [COLOR_W-1:0]   r_bg;
    logic [ADDR_W-1:0]    r_prod;
    t_row_out             r_out;

    logic [3:0]           w_w;
    logic [4:0]           w_h;
    logic [8:0]           w_mask_full;
    logic [GLYPH_W-1:0]   w_mask;
    logic                 w_edge;
    logic                 w_last;
    logic                 w_accept;
    logic                 w_load;
    logic                 w_advance;
    logic                 w_start;
    logic [ROW_IDX_W-1:0] w_rd_row;
    logic [CUR_W-1:0]     w_ry;
    logic [24:0]          w_prod_full;
    logic [7:0]           w_rd_ch;

    // Effective glyph size and row mask
    assign w_w         = (i_cfg.glyph_width > MAX_WIDTH) ? MAX_WIDTH : i_cfg.glyph_width;
    assign w_h         = (i_cfg.glyph_height > MAX_HEIGHT) ? MAX_HEIGHT : i_cfg.glyph_height;
    assign w_mask_full = (9'd1 << w_w) - 9'd1;
    assign w_mask      = w_mask_full[7:0];
    assign w_edge      = ({1'b0, r_cx} + {9'd0, w_w}) >= i_cfg.frame_width;
    assign w_last      = ({1'b0, r_row} == (w_h - 5'd1));

    // Handshakes
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = (r_state == S_EMIT) && (!r_mvalid || i_m_tready);
    assign w_start    = w_accept && (i_item.req_type == REQ_PUT)
                        && (i_item.char_code != NEWLINE_CODE) && (w_h != 5'd0);

    // Row whose font entry and product are fetched this cycle
    assign w_rd_row    = (r_state == S_READ) ? r_row : r_row + 1'b1;
    assign w_ry        = r_cy + {{(CUR_W-ROW_IDX_W){1'b0}}, w_rd_row};
    assign w_prod_full = w_ry * i_cfg.frame_width;
    assign w_rd_ch     = r_ch;

    // Font store port: loads write while idle, reads only while drawing
    always_comb begin
        o_font.we    = w_accept && (i_item.req_type == REQ_LOAD);
        o_font.waddr = {i_item.char_code, i_item.glyph_row};
        o_font.wdata = i_item.glyph_bits;
        o_font.re    = (r_state == S_READ) || (w_load && !w_last);
        o_font.raddr = {w_rd_ch, w_rd_row};
    end

    // Sequencer and cursor
    always_comb begin
        n_state   = r_state;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_row     = r_row;
        n_mvalid  = r_mvalid;
        w_advance = 1'b0;

        if (r_mvalid && i_m_tready) begin
            n_mvalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_item.req_type)
                        REQ_LOAD: ;
                        REQ_PUT: begin
                            if (i_item.char_code == NEWLINE_CODE) begin
                                n_cx = '0;
                                n_cy = r_cy + {7'd0, w_h};
                            end else if (w_h == 5'd0) begin
                                w_advance = 1'b1;
                            end else begin
                                n_row   = '0;
                                n_state = S_READ;
                            end
                        end
                        REQ_HOME: begin
                            n_cx = '0;
                            n_cy = '0;
                        end
                        REQ_NONE: ;
                    endcase
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_mvalid = 1'b1;
                    if (w_last) begin
                        w_advance = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Step the cursor after a drawn or zero-height character, wrap at the frame edge
        if (w_advance) begin
            if (w_edge) begin
                n_cx = '0;
                n_cy = r_cy + {7'd0, w_h};
            end else begin
                n_cx = r_cx + {8'd0, w_w};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cx     <= '0;
            r_cy     <= '0;
            r_row    <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_row    <= n_row;
            r_mvalid <= n_mvalid;
        end
    end

    // Hold the character and colors, the row product and the result
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_ch <= i_item.char_code;
            r_fg <= i_item.fg_color;
            r_bg <= i_item.bg_color;
        end
        if (o_font.re) begin
            r_prod <= w_prod_full[ADDR_W-1:0];
        end
        if (w_load) begin
            r_out.row_address  <= r_prod + {{(ADDR_W-CUR_W){1'b0}}, r_cx};
            r_out.row_bits     <= i_font_rdata & w_mask;
            r_out.fg_color_out <= r_fg;
            r_out.bg_color_out <= r_bg;
            r_out.last_row     <= w_last;
        end
    end

    assign o_m_tvalid = r_mvalid;
    assign o_row      = r_out;

    // A write and a read of the font store never share a cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_font.we && o_font.re))
        else $error("font store written and read in one cycle");

    // A drawn character starts with a font read
    a_start_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == S_READ) && $past(o_font.re) == 1'b0)
        else $error("put did not start a font read");

    // Each non-final result steps the row index by one
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_last) |=> (r_row == $past(r_row) + 1'b1) && (r_state == S_EMIT))
        else $error("row index did not advance");

    // The final result returns the sequencer to idle with a result pending
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_state == S_IDLE) && r_mvalid && r_out.last_row)
        else $error("last row did not close the character");

endmodule

[hdl/bitmap_font_text_renderer_top.sv]
// Top level of the bitmap font text renderer: configuration registers and stream ports.
`timescale 1ns / 1ps

// A load, home or newline transaction completes when it is taken. A put transaction
// with an effective glyph height h (glyph_height limited to 16) is taken, issues its
// first font read, then gives h results, one per cycle when the output side keeps
// up, set by the single read port of the 4096 x 8 font store that holds one glyph row
// per entry; output stalls hold the results back. A put with height zero only moves
// the cursor. The next transaction is taken once the last row has entered the output
// register, while that row still waits to be taken.
// Font entries are undefined until loaded; drawing an unloaded glyph row gives
// undefined row bits.

module bitmap_font_text_renderer_top import bfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    // Request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: char_code[7:0], glyph_row[11:8], glyph_bits[19:12], fg_color[51:20],
    //        bg_color[83:52], zero[87:84]
    input  logic [87:0] i_s_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]  i_s_tuser,
    // Row result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: row_address[23:0], row_bits[31:24], fg_color_out[63:32],
    //        bg_color_out[95:64]
    output logic [95:0] o_m_tdata,
    output logic        o_m_tlast
);

    t_cfg               r_cfg;
    t_item              w_item;
    t_font_port         w_font;
    logic [GLYPH_W-1:0] w_font_rdata;
    t_row_out           w_row;

    // Configuration registers, writes to unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= 13'd640;
            r_cfg.glyph_width  <= 4'd8;
            r_cfg.glyph_height <= 5'd16;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data;
                CFG_GLYPH_WIDTH:  r_cfg.glyph_width  <= i_cfg_data[3:0];
                CFG_GLYPH_HEIGHT: r_cfg.glyph_height <= i_cfg_data[4:0];
                CFG_UNUSED:       ;
            endcase
        end
    end

    // Unpack the request transaction
    always_comb begin
        w_item.req_type   = t_req'(i_s_tuser);
        w_item.char_code  = i_s_tdata[7:0];
        w_item.glyph_row  = i_s_tdata[11:8];
        w_item.glyph_bits = i_s_tdata[19:12];
        w_item.fg_color   = i_s_tdata[51:20];
        w_item.bg_color   = i_s_tdata[83:52];
    end

    bfr_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (FONT_DEPTH)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (w_font.we),
        .i_waddr (w_font.waddr),
        .i_wdata (w_font.wdata),
        .i_re    (w_font.re),
        .i_raddr (w_font.raddr),
        .o_rdata (w_font_rdata)
    );

    bfr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_item       (w_item),
        .o_font       (w_font),
        .i_font_rdata (w_font_rdata),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_row        (w_row)
    );

    // Pack the row result
    assign o_m_tdata = {w_row.bg_color_out, w_row.fg_color_out, w_row.row_bits,
                        w_row.row_address};
    assign o_m_tlast = w_row.last_row;

endmodule
